/* rtl/core/lpb_pkg.sv */
// ----------------------------------------------------------------------------
// lpb_pkg
// Shared types and helpers of the logistic proximal bisection unit: the
// datapath operation codes, the command and status groups between the
// controller and the datapath, and 32-bit saturation.
// ----------------------------------------------------------------------------
package lpb_pkg;

  // Operation that the datapath performs.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_SWAP   = 3'd2,
    OP_EXPAND = 3'd3,
    OP_MID    = 3'd4,
    OP_NARROW = 3'd5,
    OP_OUT    = 3'd6
  } lpb_op_t;

  // Point at which the function evaluator samples.
  typedef enum logic [1:0] {
    ZSEL_LO  = 2'd0,
    ZSEL_HI  = 2'd1,
    ZSEL_MID = 2'd2
  } lpb_zsel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    lpb_op_t   op;
    lpb_zsel_t zsel;
    logic      wr_f;
    logic      fail;
  } lpb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic flo_gt_fhi;
    logic same_sign;
    logic flo_pos;
    logic ovf;
    logic fmid_zero;
  } lpb_sts_t;

  // Register index of the penalty weight.
  localparam logic REG_LAMBDA = 1'b0;

  // Saturate a 33-bit signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/lpb_datapath.sv */
// ----------------------------------------------------------------------------
// lpb_datapath
// Bracket registers, the three-stage function evaluator (sigmoid and
// distance, penalty product, sum) and the result register.
// ----------------------------------------------------------------------------
module lpb_datapath import lpb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  lpb_cmd_t           cmd_i,
  input  logic signed [31:0] lambda_i,
  input  logic signed [31:0] ax_value_i,
  input  logic signed [31:0] u_value_i,
  input  logic signed [31:0] label_i,
  output lpb_sts_t           sts_o,
  output logic signed [31:0] root_o,
  output logic               failed_o
);

  localparam int FW = 66 - FRAC_BITS;
  localparam longint ONE = longint'(1) <<< FRAC_BITS;
  localparam logic [32:0] T_SAT = 33'(5 * ONE);
  localparam logic [32:0] T_MID = 33'((19 * ONE) / 8);
  localparam logic [32:0] T_LIN = 33'(ONE);
  localparam logic [32:0] C_HI  = 33'((27 * ONE) / 32);
  localparam logic [32:0] C_MID = 33'((5 * ONE) / 8);
  localparam logic [32:0] C_LO  = 33'(ONE / 2);
  localparam logic [32:0] C_ONE = 33'(ONE);
  localparam logic signed [31:0] LO_INIT = 32'(-10 * ONE);
  localparam logic signed [31:0] HI_INIT = 32'(10 * ONE);

  logic signed [31:0]   q_r, y_r, lo_r, hi_r, mid_r, d_r, root_r;
  logic signed [FW-1:0] flo_r, fhi_r, fmid_r;
  logic signed [33:0]   sg1_r, sg2_r;
  logic signed [63:0]   prod_r;
  logic                 failed_r;

  logic signed [31:0]   zv, d_nxt, lo2, hi2;
  logic signed [32:0]   qsum, diff, msum;
  logic [32:0]          a, s_abs, sig;
  logic signed [FW-1:0] f_val;

  // Stage one: pick the sample point, form the clipped distance and the sigmoid.
  always_comb begin
    case (cmd_i.zsel)
      ZSEL_LO:  zv = lo_r;
      ZSEL_HI:  zv = hi_r;
      default:  zv = mid_r;
    endcase
    diff  = {zv[31], zv} - {q_r[31], q_r};
    d_nxt = sat33(diff);
    a     = zv[31] ? 33'(-{zv[31], zv}) : 33'({zv[31], zv});
    if (a >= T_SAT) begin
      s_abs = C_ONE;
    end else if (a >= T_MID) begin
      s_abs = (a >> 5) + C_HI;
    end else if (a >= T_LIN) begin
      s_abs = (a >> 3) + C_MID;
    end else begin
      s_abs = (a >> 2) + C_LO;
    end
    sig = zv[31] ? (C_ONE - s_abs) : s_abs;
  end

  // Stage three: sigmoid plus floored penalty minus the label.
  assign f_val = FW'(prod_r >>> FRAC_BITS) + FW'(sg2_r) - FW'(y_r);

  // Bracket arithmetic.
  assign qsum = {ax_value_i[31], ax_value_i} + {u_value_i[31], u_value_i};
  assign msum = {lo_r[31], lo_r} + {hi_r[31], hi_r};
  assign lo2  = sat33({lo_r, 1'b0});
  assign hi2  = sat33({hi_r, 1'b0});

  // Evaluator pipeline registers run every cycle.
  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    sg1_r  <= $signed({1'b0, sig});
    prod_r <= lambda_i * d_r;
    sg2_r  <= sg1_r;
  end

  // Bracket, function value and result registers.
  always_ff @(posedge clk) begin
    case (cmd_i.op)
      OP_LOAD: begin
        q_r  <= sat33(qsum);
        y_r  <= label_i;
        lo_r <= LO_INIT;
        hi_r <= HI_INIT;
      end
      OP_SWAP: begin
        if (sts_o.flo_gt_fhi) begin
          lo_r  <= hi_r;
          hi_r  <= lo_r;
          flo_r <= fhi_r;
          fhi_r <= flo_r;
        end
      end
      OP_EXPAND: begin
        if (sts_o.flo_pos) begin
          hi_r  <= lo_r;
          fhi_r <= flo_r;
          lo_r  <= lo2;
        end else begin
          lo_r  <= hi_r;
          flo_r <= fhi_r;
          hi_r  <= hi2;
        end
      end
      OP_MID: mid_r <= msum[32:1];
      OP_NARROW: begin
        if (fmid_r[FW-1]) begin
          lo_r <= mid_r;
        end else begin
          hi_r <= mid_r;
        end
      end
      OP_OUT: begin
        root_r   <= mid_r;
        failed_r <= cmd_i.fail;
      end
      default: ;
    endcase
    if (cmd_i.wr_f) begin
      case (cmd_i.zsel)
        ZSEL_LO:  flo_r  <= f_val;
        ZSEL_HI:  fhi_r  <= f_val;
        default:  fmid_r <= f_val;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.flo_gt_fhi = flo_r > fhi_r;
    sts_o.same_sign  = (flo_r != '0) && (fhi_r != '0) && (flo_r[FW-1] == fhi_r[FW-1]);
    sts_o.flo_pos    = !flo_r[FW-1] && (flo_r != '0);
    sts_o.ovf        = sts_o.flo_pos ? (lo_r[31] ^ lo_r[30]) : (hi_r[31] ^ hi_r[30]);
    sts_o.fmid_zero  = fmid_r == '0;
  end

  assign root_o   = root_r;
  assign failed_o = failed_r;

endmodule

/* rtl/core/lpb_ctrl.sv */
// ----------------------------------------------------------------------------
// lpb_ctrl
// Sequencer of the bisection unit: evaluates the bracket ends, expands the
// bracket, runs the halvings and hands the result to the output register.
// ----------------------------------------------------------------------------
module lpb_ctrl import lpb_pkg::*; #(
  parameter int MAX_ITER   = 5,
  parameter int MAX_EXPAND = 12
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lpb_sts_t sts_i,
  output lpb_cmd_t cmd_o
);

  localparam int CW = $clog2(MAX_EXPAND + 1);
  localparam int IW = $clog2(MAX_ITER + 1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EV_LO  = 11'b000_0000_0010,
    S_EV_HI  = 11'b000_0000_0100,
    S_SWAP   = 11'b000_0000_1000,
    S_CHECK  = 11'b000_0001_0000,
    S_EXPAND = 11'b000_0010_0000,
    S_EV_EXP = 11'b000_0100_0000,
    S_MID    = 11'b000_1000_0000,
    S_EV_MID = 11'b001_0000_0000,
    S_BISECT = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

  state_t    state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] its_r, its_nxt;
  logic      fail_r, fail_nxt;
  lpb_zsel_t side_r, side_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      ev_done;

  assign ev_done = ph_r == 2'd2;

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = 2'd0;
    cnt_nxt       = cnt_r;
    its_nxt       = its_r;
    fail_nxt      = fail_r;
    side_nxt      = side_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd_o         = '{op: OP_NONE, zsel: ZSEL_LO, wr_f: 1'b0, fail: fail_r};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.op  = OP_LOAD;
          cnt_nxt   = '0;
          fail_nxt  = 1'b0;
          state_nxt = S_EV_LO;
        end
      end
      S_EV_LO: begin
        cmd_o.zsel = ZSEL_LO;
        cmd_o.wr_f = ev_done;
        ph_nxt     = ev_done ? 2'd0 : ph_r + 2'd1;
        if (ev_done) state_nxt = S_EV_HI;
      end
      S_EV_HI: begin
        cmd_o.zsel = ZSEL_HI;
        cmd_o.wr_f = ev_done;
        ph_nxt     = ev_done ? 2'd0 : ph_r + 2'd1;
        if (ev_done) state_nxt = S_SWAP;
      end
      S_SWAP: begin
        cmd_o.op  = OP_SWAP;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts_i.same_sign) begin
          state_nxt = S_MID;
        end else if (cnt_r >= CW'(MAX_EXPAND)) begin
          fail_nxt  = 1'b1;
          state_nxt = S_MID;
        end else begin
          state_nxt = S_EXPAND;
        end
      end
      S_EXPAND: begin
        cmd_o.op = OP_EXPAND;
        cnt_nxt  = cnt_r + CW'(1);
        side_nxt = sts_i.flo_pos ? ZSEL_LO : ZSEL_HI;
        if (sts_i.ovf) begin
          fail_nxt  = 1'b1;
          state_nxt = S_MID;
        end else begin
          state_nxt = S_EV_EXP;
        end
      end
      S_EV_EXP: begin
        cmd_o.zsel = side_r;
        cmd_o.wr_f = ev_done;
        ph_nxt     = ev_done ? 2'd0 : ph_r + 2'd1;
        if (ev_done) state_nxt = S_CHECK;
      end
      S_MID: begin
        cmd_o.op  = OP_MID;
        state_nxt = fail_r ? S_FIN : S_EV_MID;
      end
      S_EV_MID: begin
        cmd_o.zsel = ZSEL_MID;
        cmd_o.wr_f = ev_done;
        ph_nxt     = ev_done ? 2'd0 : ph_r + 2'd1;
        if (ev_done) state_nxt = S_BISECT;
      end
      S_BISECT: begin
        if (sts_i.fmid_zero || its_r >= IW'(MAX_ITER)) begin
          state_nxt = S_FIN;
        end else begin
          cmd_o.op  = OP_NARROW;
          its_nxt   = its_r + IW'(1);
          state_nxt = S_MID;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd_o.op      = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_IDLE) its_nxt = '0;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= 2'd0;
      cnt_r       <= '0;
      its_r       <= '0;
      fail_r      <= 1'b0;
      side_r      <= ZSEL_LO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
      its_r       <= its_nxt;
      fail_r      <= fail_nxt;
      side_r      <= side_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

endmodule

/* rtl/core/logistic_prox_bisection_unit.sv */
// ----------------------------------------------------------------------------
// logistic_prox_bisection_unit
// Proximal step of the logistic loss in signed fixed point, found by
// bracketing and bisection on one shared function evaluator.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_ax_value, in_u_value, in_label) is taken on a valid/ready
//   transfer while the unit is idle. The unit forms q = ax + u and searches
//   for z with sigmoid(z) + lambda*(z - q) - label = 0. The result
//   (out_root, out_bracket_failed) is presented on a valid/ready transfer.
//   Each evaluation of the function passes through the evaluator stages
//   (sigmoid and distance, penalty product, final sum), and every step of the
//   search waits on it. The twelfth doubling of the default bracket
//   saturates, and the search makes at most MAX_ITER halvings.
//   One item is in flight at a time; the next item may be taken while the
//   previous result still waits in the output register. If the receiver
//   stalls, the finished result holds the sequencer until the output frees.
//   The penalty weight lambda is written over the APB port at address 0;
//   the user must write it only while the unit is idle, as the unit does not
//   enforce it. Reset sets lambda to 1.0 and empties the output register.
// ----------------------------------------------------------------------------
module logistic_prox_bisection_unit import lpb_pkg::*; #(
  parameter int MAX_ITER   = 5,
  parameter int MAX_EXPAND = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_ax_value,
  input  logic signed [31:0] in_u_value,
  input  logic signed [31:0] in_label,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_root,
  output logic               out_bracket_failed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic signed [31:0] LAMBDA_RESET = 32'(longint'(1) <<< FRAC_BITS);

  logic signed [31:0] lambda_r;
  lpb_cmd_t           cmd;
  lpb_sts_t           sts;

  // Configuration register write and read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lambda_r <= LAMBDA_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_LAMBDA) begin
      lambda_r <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LAMBDA) ? lambda_r : 32'd0;

  lpb_ctrl #(
    .MAX_ITER   (MAX_ITER),
    .MAX_EXPAND (MAX_EXPAND)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  lpb_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .cmd_i      (cmd),
    .lambda_i   (lambda_r),
    .ax_value_i (in_ax_value),
    .u_value_i  (in_u_value),
    .label_i    (in_label),
    .sts_o      (sts),
    .root_o     (out_root),
    .failed_o   (out_bracket_failed)
  );

  // The sequencer is busy right after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("unit still ready after taking an item");

  // A fresh result never appears in the cycle after an item is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result presented without any evaluation");

endmodule

/* verif/logistic_prox_bisection_unit_tb.sv */
// ----------------------------------------------------------------------------
// logistic_prox_bisection_unit_tb
// Self-checking bench for the bisection unit. A scoreboard class predicts
// each root and failure flag from the accepted input and the current
// penalty weight. Directed items cover the field extremes, exact zeros,
// capped and saturated expansion. Random items follow, under bursty input,
// patterned output stalls and several lambda settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module logistic_prox_bisection_unit_tb import lpb_pkg::*;;

  localparam int ITER_LIMIT   = 5;
  localparam int EXPAND_LIMIT = 12;
  localparam int FRAC         = 16;
  localparam longint ONE      = 64'sd1 <<< FRAC;
  localparam longint S32_MAX  = 64'sd2147483647;
  localparam longint S32_MIN  = -64'sd2147483648;
  localparam int DRAIN_CYCLES = 150;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  logic signed [31:0] in_ax_value, in_u_value, in_label;
  logic out_valid, out_ready;
  logic signed [31:0] out_root;
  logic out_bracket_failed;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  int mismatch_count = 0;
  bit hold_off = 0;
  int stall_mode = 0;

  logistic_prox_bisection_unit dut (.*);

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Predicts the root search and holds the expected results in order.
  class root_scoreboard;
    longint weight = ONE;
    logic signed [31:0] root_q[$];
    logic fail_q[$];

    function longint clip32(longint x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
    endfunction

    function longint floor_shift(longint x, int n);
      return x >>> n;
    endfunction

    function longint sigmoid_pwl(longint z);
      longint a, s;
      a = (z < 0) ? -z : z;
      if (a >= 5 * ONE) s = ONE;
      else if (a >= (19 * ONE) / 8) s = (a >>> 5) + (27 * ONE) / 32;
      else if (a >= ONE) s = (a >>> 3) + (5 * ONE) / 8;
      else s = (a >>> 2) + ONE / 2;
      return (z < 0) ? ONE - s : s;
    endfunction

    function longint residual(longint z, longint q, longint y);
      longint d;
      d = clip32(z - q);
      return sigmoid_pwl(z) + floor_shift(weight * d, FRAC) - y;
    endfunction

    function int sign_of(longint x);
      return (x > 0) - (x < 0);
    endfunction

    function void note_item(logic signed [31:0] ax, logic signed [31:0] u,
                            logic signed [31:0] y32);
      longint q, y, lo, hi, flo, fhi, mid, fmid, t, nv;
      bit failed;
      int count, its;
      q = clip32(longint'(ax) + longint'(u));
      y = longint'(y32);
      lo = -10 * ONE;
      hi = 10 * ONE;
      flo = residual(lo, q, y);
      fhi = residual(hi, q, y);
      failed = 0;
      count = 0;
      if (flo > fhi) begin
        t = lo; lo = hi; hi = t;
        t = flo; flo = fhi; fhi = t;
      end
      // Move and double the bracket until the signs differ.
      while (sign_of(flo) * sign_of(fhi) > 0) begin
        if (count >= EXPAND_LIMIT) begin
          failed = 1;
          break;
        end
        if (flo > 0) begin
          hi = lo;
          nv = clip32(lo * 2);
          if (nv != lo * 2) failed = 1;
          lo = nv;
        end else begin
          lo = hi;
          nv = clip32(hi * 2);
          if (nv != hi * 2) failed = 1;
          hi = nv;
        end
        count++;
        flo = residual(lo, q, y);
        fhi = residual(hi, q, y);
        if (failed) break;
      end
      mid = floor_shift(lo + hi, 1);
      // Halve the bracket.
      if (!failed) begin
        fmid = residual(mid, q, y);
        its = 0;
        while (fmid != 0 && its < ITER_LIMIT) begin
          if (fmid < 0) lo = mid;
          else hi = mid;
          mid = floor_shift(lo + hi, 1);
          fmid = residual(mid, q, y);
          its++;
        end
      end
      root_q.push_back(mid[31:0]);
      fail_q.push_back(failed);
    endfunction

    task check_result(logic signed [31:0] r, logic f);
      logic signed [31:0] er;
      logic ef;
      if (root_q.size() == 0) begin
        report("result transfer with nothing expected");
        return;
      end
      er = root_q.pop_front();
      ef = fail_q.pop_front();
      if (r !== er) report($sformatf("root got %0d expected %0d", r, er));
      if (f !== ef) report($sformatf("bracket_failed got %0b expected %0b", f, ef));
    endtask

    function int pending();
      return root_q.size();
    endfunction
  endclass

  root_scoreboard board = new();

  // Result side: sample transfers and stall on a pattern or at random.
  int out_cycle = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_root, out_bracket_failed);
    out_cycle <= out_cycle + 1;
    if (!rst_n || hold_off) out_ready <= 1'b0;
    else if (stall_mode == 0) out_ready <= 1'b1;
    else if (stall_mode == 1) out_ready <= (out_cycle % 7) < 4;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Input side: note each accepted item.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      board.note_item(in_ax_value, in_u_value, in_label);
  end

  task automatic send_item(input logic [31:0] ax, input logic [31:0] u,
                           input logic [31:0] y);
    in_valid <= 1'b1;
    in_ax_value <= ax;
    in_u_value <= u;
    in_label <= y;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_input(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_input(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_lambda(input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_LAMBDA, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.weight = longint'($signed(v));
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 40 * 65536) - 20 * 65536;
      2: return $urandom_range(0, 65536);
      3: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
      default: return $urandom_range(0, 65536 * 1000) - 65536 * 500;
    endcase
  endfunction

  task automatic random_phase(input int n);
    int left;
    left = n;
    while (left > 0) begin
      int burst;
      burst = $urandom_range(1, 8);
      while (burst > 0 && left > 0) begin
        send_item(rand_value(), rand_value(), rand_value());
        burst--;
        left--;
      end
      if ($urandom_range(0, 2) == 0) idle_input($urandom_range(1, 60));
    end
  endtask

  initial begin
    logic [31:0] weights[6];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_ax_value = '0;
    in_u_value = '0;
    in_label = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items with the reset weight of 1.0.
    send_item(32'h0, 32'h0, 32'h0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h0);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(32'h0, 32'h0, 32'h8000_0000);
    send_item(32'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(32'h0001_0000, 32'h0, 32'h0000_8000);
    send_item(32'h0, 32'h0, 32'h0000_8000);
    send_item(32'h0050_0000, 32'h0, 32'h0);
    send_item(32'hFFB0_0000, 32'h0, 32'h0001_0000);
    send_item(32'h0, 32'h0, 32'h0005_0000);
    send_item(32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678);
    drain();

    // Zero weight: expansion runs to the cap or saturates.
    write_lambda(32'h0);
    send_item(32'h0, 32'h0, 32'h0);
    send_item(32'h0, 32'h0, 32'h0001_0000);
    send_item(32'h0, 32'h0, 32'h0000_8000);
    send_item(32'h0, 32'h0, 32'h0000_C000);
    drain();

    // Negative extreme weight.
    write_lambda(32'h8000_0000);
    send_item(32'h0, 32'h0, 32'h0);
    send_item(32'h0, 32'h0, 32'h7FFF_FFFF);
    send_item(32'h0100_0000, 32'h0, 32'h8000_0000);
    drain();

    // Random phases over several weights.
    weights = '{32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_0100,
                32'hFFFF_0000, 32'h0010_0000, 32'h8000_0000};
    foreach (weights[i]) begin
      write_lambda(weights[i]);
      stall_mode = i % 3;
      random_phase(55);
      drain();
    end

    // Long receiver hold-off while the sender keeps offering items.
    write_lambda($urandom());
    stall_mode = 2;
    fork
      begin
        hold_off = 1;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      random_phase(20);
    join
    drain();

    // Final random phase, with a random weight.
    write_lambda($urandom_range(0, 4 * 65536));
    stall_mode = 1;
    random_phase(50);
    drain();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
